FILE: rtl/core/clc_pkg.sv
// Shared types, constants and helpers for the code lock controller.
// No dependencies; imported by clc_step and code_lock_controller_core.
`timescale 1ns / 1ps

package clc_pkg;

  localparam int CODE_DIGITS = 4;
  localparam int DIGIT_W     = 4;
  localparam int POS_W       = (CODE_DIGITS > 1) ? $clog2(CODE_DIGITS) : 1;
  localparam int CODE_W      = 16;
  localparam int ATT_W       = 4;
  localparam int EVENT_W     = 3;

  localparam logic [POS_W-1:0] LAST_POS = POS_W'(CODE_DIGITS - 1);

  localparam logic [CODE_W-1:0] DURESS_RESET = 16'h1233;
  localparam logic [ATT_W-1:0]  MAX_ATT_RESET = 4'd3;

  // register indexes
  localparam logic REG_DURESS  = 1'b0;
  localparam logic REG_MAX_ATT = 1'b1;

  // result events
  localparam logic [EVENT_W-1:0] EV_DIGIT    = 3'd0;
  localparam logic [EVENT_W-1:0] EV_REFUSED  = 3'd1;
  localparam logic [EVENT_W-1:0] EV_ENROLLED = 3'd2;
  localparam logic [EVENT_W-1:0] EV_GRANTED  = 3'd3;
  localparam logic [EVENT_W-1:0] EV_DURESS   = 3'd4;
  localparam logic [EVENT_W-1:0] EV_WRONG    = 3'd5;
  localparam logic [EVENT_W-1:0] EV_LOCKOUT  = 3'd6;

  typedef logic [CODE_DIGITS-1:0][DIGIT_W-1:0] digits_t;

  typedef struct packed {
    logic              verify_mode;
    logic [POS_W-1:0]  digit_position;
    logic [ATT_W-1:0]  attempts_left;
  } ctrl_t;

  // first field in the high bits
  typedef struct packed {
    logic [CODE_W-1:0]  revealed_code;
    logic [ATT_W-1:0]   attempts_remaining;
    logic [EVENT_W-1:0] event_res;
  } res_t;

  // digit i of the duress code; first digit sits in nibble CODE_DIGITS-1
  function automatic logic [DIGIT_W-1:0] duress_digit(input logic [CODE_W-1:0] code,
                                                      input int i);
    int nib;
    logic [DIGIT_W-1:0] d;
    nib = CODE_DIGITS - 1 - i;
    d = '0;
    if (nib < CODE_W / 4) d = code[4*nib +: 4];
    return d;
  endfunction

  function automatic logic [CODE_W-1:0] digits_as_bcd(input digits_t dg);
    logic [CODE_W-1:0] v;
    int nib;
    v = '0;
    for (int i = 0; i < CODE_DIGITS; i++) begin
      nib = CODE_DIGITS - 1 - i;
      if (nib < CODE_W / 4) v[4*nib +: 4] = dg[i];
    end
    return v;
  endfunction

endpackage

FILE: rtl/core/code_lock_controller_core.sv
// Code lock controller top level: key register, evaluation, result register.
// Depends on clc_pkg and clc_step.
`timescale 1ns / 1ps
//
// Usage:
//   s_* carries one decoded key digit per beat (s_tdata[3:0]).
//   m_* carries one result beat per key: event, attempts left, and the
//   revealed stored code on lockout.
//   cfg_we/cfg_index/cfg_wdata write the duress code (index 0) and the
//   attempt budget (index 1); write only while no key is in flight.
// Timing:
//   A key is captured in the key register, evaluated by combinational logic
//   and registered in the result register. One key per cycle is sustained
//   while m_tready stays high; the only loop is the control state update,
//   which closes through that evaluation logic.
// Reset:
//   Enroll mode, digit position and attempt count cleared, both pipeline
//   stages empty, registers back to duress 1233 and three attempts.
// Stall:
//   While m_tready is low the result holds; the key register still takes
//   one more beat, then s_tready drops until the result is taken.

module code_lock_controller_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [7:0]                     s_tdata,   // [3:0] key_digit
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [23:0]                    m_tdata,   // [2:0] event_res,
                                                    // [6:3] attempts_remaining,
                                                    // [22:7] revealed_code
  input  logic                           cfg_we,
  input  logic                           cfg_index,
  input  logic [clc_pkg::CODE_W-1:0]     cfg_wdata
);
  import clc_pkg::*;

  logic [CODE_W-1:0]  duress_code;
  logic [ATT_W-1:0]   max_attempts;

  logic               key_valid;
  logic [DIGIT_W-1:0] key_digit;
  logic               out_valid;
  res_t               out_res;

  ctrl_t   ctrl;
  ctrl_t   ctrl_next;
  digits_t stored_code;
  digits_t entry_digits;
  digits_t entry_next;
  logic    store_we;
  res_t    res;
  logic    advance;

  assign advance  = key_valid && (!out_valid || m_tready);
  assign s_tready = !key_valid || advance;
  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, out_res};

  always_ff @(posedge clk) begin
    if (rst) begin
      duress_code  <= DURESS_RESET;
      max_attempts <= MAX_ATT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DURESS:  duress_code  <= cfg_wdata;
        REG_MAX_ATT: max_attempts <= cfg_wdata[ATT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_valid <= 1'b0;
    end else if (s_tready) begin
      key_valid <= s_tvalid;
    end
    if (s_tready && s_tvalid) key_digit <= s_tdata[DIGIT_W-1:0];
  end

  clc_step u_step (
    .ctrl         (ctrl),
    .key_digit    (key_digit),
    .stored_code  (stored_code),
    .entry_digits (entry_digits),
    .duress_code  (duress_code),
    .max_attempts (max_attempts),
    .ctrl_next    (ctrl_next),
    .entry_next   (entry_next),
    .store_we     (store_we),
    .res          (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl <= '0;
    end else if (advance) begin
      ctrl <= ctrl_next;
    end
    if (advance) begin
      entry_digits <= entry_next;
      if (store_we) stored_code <= entry_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
    if (advance) out_res <= res;
  end

  // enroll mode never carries an attempt budget
  a_enroll_no_budget: assert property (@(posedge clk) disable iff (rst)
    !ctrl.verify_mode |-> ctrl.attempts_left == '0)
    else $error("attempt count nonzero in enroll mode");

  a_lockout_zero_left: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.event_res == EV_LOCKOUT |-> out_res.attempts_remaining == '0)
    else $error("lockout reports attempts left");

  a_reveal_only_lockout: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.event_res != EV_LOCKOUT |-> out_res.revealed_code == '0)
    else $error("code revealed outside lockout");

  a_final_exits_verify: assert property (@(posedge clk) disable iff (rst)
    advance && (res.event_res == EV_GRANTED || res.event_res == EV_DURESS ||
                res.event_res == EV_LOCKOUT)
    |=> !ctrl.verify_mode && ctrl.digit_position == '0)
    else $error("final outcome did not return to enroll mode");

  a_result_follows_key: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("evaluated key produced no result");

endmodule

FILE: rtl/core/clc_step.sv
// Per-key evaluation: next control state, entry digits and the result beat.
// Depends on clc_pkg.
`timescale 1ns / 1ps

module clc_step (
  input  clc_pkg::ctrl_t                  ctrl,
  input  logic [clc_pkg::DIGIT_W-1:0]     key_digit,
  input  clc_pkg::digits_t                stored_code,
  input  clc_pkg::digits_t                entry_digits,
  input  logic [clc_pkg::CODE_W-1:0]      duress_code,
  input  logic [clc_pkg::ATT_W-1:0]       max_attempts,
  output clc_pkg::ctrl_t                  ctrl_next,
  output clc_pkg::digits_t                entry_next,
  output logic                            store_we,
  output clc_pkg::res_t                   res
);
  import clc_pkg::*;

  logic is_duress;
  logic is_stored;

  always_comb begin
    entry_next = entry_digits;
    entry_next[ctrl.digit_position] = key_digit;
  end

  always_comb begin
    is_duress = 1'b1;
    is_stored = 1'b1;
    for (int i = 0; i < CODE_DIGITS; i++) begin
      if (entry_next[i] != duress_digit(duress_code, i)) is_duress = 1'b0;
      if (entry_next[i] != stored_code[i]) is_stored = 1'b0;
    end
  end

  always_comb begin
    ctrl_next = ctrl;
    store_we  = 1'b0;
    res       = '0;
    if (ctrl.digit_position != LAST_POS) begin
      ctrl_next.digit_position = POS_W'(ctrl.digit_position + 1'b1);
      res.event_res = EV_DIGIT;
      res.attempts_remaining = ctrl.verify_mode ? ctrl.attempts_left : '0;
    end else begin
      ctrl_next.digit_position = '0;
      if (!ctrl.verify_mode) begin
        if (is_duress) begin
          res.event_res = EV_REFUSED;
        end else begin
          store_we = 1'b1;
          ctrl_next.verify_mode = 1'b1;
          ctrl_next.attempts_left = max_attempts;
          res.event_res = EV_ENROLLED;
          res.attempts_remaining = max_attempts;
        end
      end else if (is_duress) begin
        res.event_res = EV_DURESS;
        res.attempts_remaining = ctrl.attempts_left;
        ctrl_next.verify_mode = 1'b0;
        ctrl_next.attempts_left = '0;
      end else if (is_stored) begin
        res.event_res = EV_GRANTED;
        res.attempts_remaining = ctrl.attempts_left;
        ctrl_next.verify_mode = 1'b0;
        ctrl_next.attempts_left = '0;
      end else if (ctrl.attempts_left <= ATT_W'(1)) begin
        res.event_res = EV_LOCKOUT;
        res.revealed_code = digits_as_bcd(stored_code);
        ctrl_next.verify_mode = 1'b0;
        ctrl_next.attempts_left = '0;
      end else begin
        ctrl_next.attempts_left = ctrl.attempts_left - 1'b1;
        res.event_res = EV_WRONG;
        res.attempts_remaining = ctrl.attempts_left - 1'b1;
      end
    end
  end

endmodule

FILE: tb/tb.sv
// Self-checking bench for code_lock_controller_core: drives keypad digits, checks result beats.
// Depends on clc_pkg and code_lock_controller_core; the expected beats come from a local lock model.
`timescale 1ns / 1ps

module tb;
  import clc_pkg::*;

  localparam int PHASES      = 6;
  localparam int PHASE_KEYS  = 300;
  localparam int QUIET_LIMIT = 2000;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [7:0]          s_tdata = '0;   // [3:0] key_digit
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [23:0]         m_tdata;        // [2:0] event_res, [6:3] attempts_remaining,
                                       // [22:7] revealed_code
  logic                cfg_we = 1'b0;
  logic                cfg_index = 1'b0;
  logic [CODE_W-1:0]   cfg_wdata = '0;

  code_lock_controller_core dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // lock model state and register copies
  logic [CODE_W-1:0]  cfg_duress = DURESS_RESET;
  logic [ATT_W-1:0]   cfg_max_att = MAX_ATT_RESET;
  logic               lk_verify = 1'b0;
  logic [POS_W-1:0]   lk_pos = '0;
  logic [DIGIT_W-1:0] lk_stored [CODE_DIGITS];
  logic [DIGIT_W-1:0] lk_entry [CODE_DIGITS];
  logic [ATT_W-1:0]   lk_att = '0;

  logic [DIGIT_W-1:0] key_q [$];
  res_t               result_q [$];

  int n_pushed = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_err = 0;
  int n_cfg = 0;
  int ev_seen [8];
  int send_gap = 0;
  int stall_left = 0;
  int quiet = 0;

  function automatic res_t next_lock_result(input logic [DIGIT_W-1:0] key);
    res_t r;
    logic hit_duress;
    logic hit_stored;
    r = '0;
    lk_entry[lk_pos] = key;
    if (lk_pos != LAST_POS) begin
      lk_pos = lk_pos + 1'b1;
      r.event_res = EV_DIGIT;
      r.attempts_remaining = lk_verify ? lk_att : '0;
    end else begin
      lk_pos = '0;
      hit_duress = 1'b1;
      hit_stored = 1'b1;
      for (int i = 0; i < CODE_DIGITS; i++) begin
        if (lk_entry[i] != cfg_duress[4*(CODE_DIGITS-1-i) +: 4]) hit_duress = 1'b0;
        if (lk_entry[i] != lk_stored[i]) hit_stored = 1'b0;
      end
      if (!lk_verify) begin
        if (hit_duress) begin
          r.event_res = EV_REFUSED;
        end else begin
          lk_stored = lk_entry;
          lk_verify = 1'b1;
          lk_att = cfg_max_att;
          r.event_res = EV_ENROLLED;
          r.attempts_remaining = lk_att;
        end
      end else if (hit_duress || hit_stored) begin
        r.event_res = hit_duress ? EV_DURESS : EV_GRANTED;
        r.attempts_remaining = lk_att;
        lk_verify = 1'b0;
        lk_att = '0;
      end else if (lk_att <= 1) begin
        // zero budget acts as one
        r.event_res = EV_LOCKOUT;
        for (int i = 0; i < CODE_DIGITS; i++)
          r.revealed_code[4*(CODE_DIGITS-1-i) +: 4] = lk_stored[i];
        lk_verify = 1'b0;
        lk_att = '0;
      end else begin
        lk_att = lk_att - 1'b1;
        r.event_res = EV_WRONG;
        r.attempts_remaining = lk_att;
      end
    end
    ev_seen[r.event_res]++;
    return r;
  endfunction

  function automatic int pick_gap(input bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      n_err++;
      $display("%0t: %s mismatch, expected %0d got %0d", $time, name, want, got);
    end
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata <= '0;
      send_gap = 0;
    end else if (!s_tvalid || s_tready) begin
      if (send_gap > 0) begin
        send_gap--;
        s_tvalid <= 1'b0;
      end else if (key_q.size() > 0) begin
        s_tdata <= {4'b0000, key_q.pop_front()};
        s_tvalid <= 1'b1;
        n_sent++;
        send_gap = pick_gap((n_sent / 150) % 4 == 3);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // monitor: checks output beats, then predicts for the key beat of this edge
  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (rst) begin
      m_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = res_t'(m_tdata[22:0]);
        if (result_q.size() == 0) begin
          n_err++;
          $display("%0t: unexpected result beat, expected none got %h", $time, m_tdata);
        end else begin
          want = result_q.pop_front();
          check_field("event_res", 32'(want.event_res), 32'(got.event_res));
          check_field("attempts_remaining", 32'(want.attempts_remaining),
                      32'(got.attempts_remaining));
          check_field("revealed_code", 32'(want.revealed_code), 32'(got.revealed_code));
          n_checked++;
        end
      end
      if (s_tvalid && s_tready)
        result_q.push_back(next_lock_result(s_tdata[DIGIT_W-1:0]));
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        stall_left = pick_gap((n_checked / 150) % 4 == 1);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("code_lock_controller_core test failed");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic push_code(input logic [CODE_W-1:0] c);
    for (int i = 0; i < CODE_DIGITS; i++)
      key_q.push_back(c[4*(CODE_DIGITS-1-i) +: 4]);
    n_pushed += CODE_DIGITS;
  endtask

  function automatic logic [CODE_W-1:0] rand_code();
    logic [CODE_W-1:0] c;
    for (int i = 0; i < CODE_DIGITS; i++)
      c[4*i +: 4] = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(10, 15))
                                                : 4'($urandom_range(0, 9));
    return c;
  endfunction

  // same code with one digit changed
  function automatic logic [CODE_W-1:0] near_code(input logic [CODE_W-1:0] c);
    int k;
    k = $urandom_range(0, CODE_DIGITS - 1);
    c[4*k +: 4] = c[4*k +: 4] + 4'($urandom_range(1, 15));
    return c;
  endfunction

  task automatic push_keys(input int n);
    for (int i = 0; i < n; i++)
      key_q.push_back(4'($urandom_range(0, 15)));
    n_pushed += n;
  endtask

  task automatic add_session();
    logic [CODE_W-1:0] code;
    int tries;
    int pick;
    int budget;
    push_keys((CODE_DIGITS - n_pushed % CODE_DIGITS) % CODE_DIGITS);
    code = ($urandom_range(0, 9) == 0) ? cfg_duress : rand_code();
    push_code(code);
    if ($urandom_range(0, 4) == 0) begin
      budget = (cfg_max_att == 0) ? 1 : cfg_max_att;
      for (int t = 0; t < budget; t++) push_code(near_code(code));
    end else begin
      tries = $urandom_range(1, 16);
      for (int t = 0; t < tries; t++) begin
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
          push_keys($urandom_range(1, CODE_DIGITS - 1));
        end else if (pick < 30) begin
          push_code(code);
          break;
        end else if (pick < 40) begin
          push_code(cfg_duress);
          break;
        end else if (pick < 70) begin
          push_code(near_code(code));
        end else begin
          push_code(rand_code());
        end
      end
    end
  endtask

  task automatic wait_idle();
    while (key_q.size() != 0 || s_tvalid || result_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic idx, input logic [CODE_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == REG_DURESS) cfg_duress = val;
    else cfg_max_att = val[ATT_W-1:0];
    n_cfg++;
  endtask

  initial begin
    logic [CODE_W-1:0] dur;
    logic [ATT_W-1:0]  att;
    for (int i = 0; i < CODE_DIGITS; i++) begin
      lk_stored[i] = '0;
      lk_entry[i] = '0;
    end
    foreach (ev_seen[i]) ev_seen[i] = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    for (int p = 0; p < PHASES; p++) begin
      if (p == 0) begin
        // reset registers: duress 1233, three attempts
        push_code(16'h1233);   // duress refused at enrollment
        push_code(16'hFFFF);   // non-decimal keys enroll
        push_code(16'h0000);   // wrong
        push_code(16'h1233);   // duress reported
        push_code(16'h9090);   // enroll
        push_code(16'h9090);   // granted
      end else begin
        wait_idle();
        case (p)
          1: begin dur = 16'h0000; att = 4'd1; end
          2: begin dur = 16'h9999; att = 4'd15; end
          3: begin dur = 16'($urandom); att = 4'd0; end
          4: begin
            for (int i = 0; i < CODE_DIGITS; i++) dur[4*i +: 4] = 4'($urandom_range(0, 9));
            att = 4'($urandom_range(1, 15));
          end
          default: begin dur = DURESS_RESET; att = MAX_ATT_RESET; end
        endcase
        cfg_write(REG_DURESS, dur);
        cfg_write(REG_MAX_ATT, {{(CODE_W-ATT_W){1'b0}}, att});
        @(posedge clk);
        cfg_we <= 1'b0;
      end
      while (n_pushed < (p + 1) * PHASE_KEYS) add_session();
    end

    wait_idle();
    repeat (8) @(posedge clk);
    $display("Sent %0d keys over %0d register settings, checked %0d result beats.",
             n_sent, n_cfg / 2 + 1, n_checked);
    $display("Events: refused %0d, enrolled %0d, granted %0d, duress %0d, wrong %0d, lockout %0d.",
             ev_seen[EV_REFUSED], ev_seen[EV_ENROLLED], ev_seen[EV_GRANTED],
             ev_seen[EV_DURESS], ev_seen[EV_WRONG], ev_seen[EV_LOCKOUT]);
    if (n_err == 0 && result_q.size() == 0) begin
      $display("code_lock_controller_core test passed");
    end else begin
      $display("code_lock_controller_core test failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/clc_pkg.sv
rtl/core/clc_step.sv
rtl/core/code_lock_controller_core.sv
tb/tb.sv
